// File: hdl/mbd_pkg.sv
// Package for the Monod bioreactor rate block: field widths, constants and
// the register index codes. No dependencies.
package mbd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int WORD_W = 32;
  localparam int CFG_W = 23;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_GROWTH = 3'd0,
    REG_HALF_SAT = 3'd1,
    REG_YIELD = 3'd2,
    REG_FEED_SUB = 3'd3,
    REG_DEATH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] biomass;
    logic signed [31:0] substrate;
    logic signed [31:0] volume;
    logic signed [31:0] feed_rate;
    logic feed_present;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] biomass_rate;
    logic signed [31:0] substrate_rate;
    logic signed [31:0] volume_rate;
    logic [30:0] biomass_clamped;
    logic [30:0] substrate_clamped;
  } out_item_t;
endpackage

// File: hdl/mbd_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Does not depend on mbd_pkg; the payload type is a parameter.
interface mbd_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/monod_bioreactor_derivatives.sv
// Top level of the Monod fed-batch bioreactor rate block.
// Depends on mbd_pkg, mbd_stream_if and mbd_divider.
//
// Computes dX, dS, dV and the clamped X and S for one state sample per
// transaction. The block is one pipeline that takes a new transaction every
// cycle while the output is not stalled. Its stages, in order, are the
// input register, the 50-stage growth rate divider (the 48-stage dilution
// divider runs beside it behind a two-register delay line), two stages
// that form mu*X and the growth term, the 64-stage consumption divider, two
// stages for the wide products built from 32-bit pieces, and the output
// register. The whole pipeline advances when the output register is empty or
// being taken, so a stall freezes every stage and nothing is lost or
// repeated. Configuration writes take effect at once and must be made with
// the pipeline empty. Register indexes are the order max_growth_rate,
// half_saturation, yield_coefficient, feed_substrate, death_rate.
module monod_bioreactor_derivatives (
  input  logic clk,
  input  logic rst,
  mbd_stream_if.sink   in_ch,
  mbd_stream_if.source out_ch,
  input  logic cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0] cfg_data
);
  localparam int FRAC_BITS = mbd_pkg::FRAC_BITS;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [31:0] HUND_Q = 32'((ONE_Q + 64'd50) / 64'd100);
  localparam int DN_W = 32 + FRAC_BITS;   // dilution numerator width
  localparam int MN_W = 50;               // mu numerator: 18 x 31 bits
  localparam int CN_W = 64;               // consumption numerator
  localparam int G_W = 40;                // |D| < 2^38, growth term < 2^39
  localparam int G_LO = 20;               // low piece of a split product
  localparam logic signed [71:0] MAXP = 72'sd2147483647;
  localparam logic signed [71:0] MINP = -72'sd2147483648;

  // Configuration registers.
  logic [17:0] mu_max;
  logic [18:0] ks;
  logic [16:0] yxs;
  logic [22:0] sf;
  logic [13:0] kd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_max <= 18'(((ONE_Q * 64'd4) + 64'd5) / 64'd10);
      ks <= 19'((ONE_Q + 64'd5) / 64'd10);
      yxs <= 17'((ONE_Q + 64'd1) / 64'd2);
      sf <= 23'(ONE_Q * 64'd10);
      kd <= 14'(HUND_Q);
    end else if (cfg_we) begin
      case (mbd_pkg::cfg_reg_t'(cfg_index))
        mbd_pkg::REG_MAX_GROWTH: mu_max <= cfg_data[17:0];
        mbd_pkg::REG_HALF_SAT: ks <= cfg_data[18:0];
        mbd_pkg::REG_YIELD: yxs <= cfg_data[16:0];
        mbd_pkg::REG_FEED_SUB: sf <= cfg_data;
        mbd_pkg::REG_DEATH: kd <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together; hold on a stalled output.
  logic advance;
  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // Stage 1: clamp, pick feed, form dividends.
  logic v1;
  logic [30:0] x1, s1;
  logic signed [31:0] f1;
  logic [31:0] vv1;
  logic [MN_W-1:0] mnum1;

  always_ff @(posedge clk) begin
    logic signed [31:0] xi, si, vi;
    xi = in_ch.data.biomass;
    si = in_ch.data.substrate;
    vi = in_ch.data.volume;
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_ch.valid;
    end
    if (advance) begin
      x1 <= xi[31] ? '0 : xi[30:0];
      s1 <= si[31] ? '0 : si[30:0];
      f1 <= in_ch.data.feed_present ? in_ch.data.feed_rate : $signed(HUND_Q);
      vv1 <= (vi < $signed(HUND_Q)) ? HUND_Q : vi;
    end
  end

  assign mnum1 = MN_W'(mu_max) * MN_W'(s1);

  // Ks+S fits 32 bits; flag the zero divisor so mu drops to zero.
  logic [31:0] mden_full;
  assign mden_full = 32'(ks) + 32'(s1);

  // Dilution divider on |F|*2^FRAC_BITS / V, sign carried in the tag.
  logic [DN_W-1:0] dnum1;
  logic [31:0] fabs1;
  assign fabs1 = f1[31] ? 32'(-f1) : 32'(f1);
  assign dnum1 = {fabs1, {FRAC_BITS{1'b0}}};

  // Tag for mu divider: x, s, f, zero divisor.
  localparam int MT_W = 31 + 31 + 32 + 1;
  logic mv2;
  logic [MN_W-1:0] mq2;
  logic [MT_W-1:0] mt2;
  mbd_divider #(.NUM_W(MN_W), .DEN_W(32), .TAG_W(MT_W)) u_mu_div (
    .clk, .rst, .advance,
    .in_valid(v1),
    .num(mnum1),
    .den(mden_full),
    .tag_in({x1, s1, f1, (mden_full == '0)}),
    .out_valid(mv2),
    .quo(mq2),
    .tag_out(mt2)
  );

  // Dilution runs alongside, then is delayed to line up with mu.
  logic dv2;
  logic [DN_W-1:0] dq2;
  logic [0:0] dsg2;
  mbd_divider #(.NUM_W(DN_W), .DEN_W(32), .TAG_W(1)) u_d_div (
    .clk, .rst, .advance,
    .in_valid(v1),
    .num(dnum1),
    .den(vv1),
    .tag_in(f1[31]),
    .out_valid(dv2),
    .quo(dq2),
    .tag_out(dsg2)
  );

  localparam int DLY = MN_W - DN_W;
  logic signed [DN_W:0] d_now;
  logic signed [DN_W:0] d_line [DLY];
  assign d_now = dsg2[0] ? -$signed({1'b0, dq2}) : $signed({1'b0, dq2});
  always_ff @(posedge clk) begin
    if (advance) begin
      d_line[0] <= d_now;
      for (int k = 1; k < DLY; k++) d_line[k] <= d_line[k-1];
    end
  end

  // Stage A: register the mu result, the lined-up D and the yield.
  logic [30:0] x2, s2;
  logic signed [31:0] f2;
  logic dz2;
  logic [MN_W-1:0] mu2;
  assign {x2, s2, f2, dz2} = mt2;
  assign mu2 = dz2 ? '0 : mq2;

  logic va;
  logic [30:0] xa, sa;
  logic signed [31:0] fa;
  logic [18:0] mua;
  logic signed [DN_W:0] da;
  logic [16:0] ya;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (advance) begin
      va <= mv2;
    end
    if (advance) begin
      xa <= x2; sa <= s2; fa <= f2;
      mua <= mu2[18:0];
      da <= d_line[DLY-1];
      ya <= (yxs == '0) ? 17'd1 : yxs;
    end
  end

  // Stage B: products. mu < 2^18 fits 19 bits; x 31 bits.
  logic vb;
  logic [49:0] mux_b;
  logic signed [G_W-1:0] gterm_b;
  logic signed [G_W-1:0] sterm_b;
  logic [30:0] xb, sb;
  logic signed [31:0] fb;
  logic [16:0] yb;
  always_ff @(posedge clk) begin
    logic signed [71:0] g;
    g = 72'(signed'({1'b0, mua})) - 72'(signed'({1'b0, kd})) - 72'(da);
    if (rst) begin
      vb <= 1'b0;
    end else if (advance) begin
      vb <= va;
    end
    if (advance) begin
      mux_b <= 50'(mua) * 50'(xa);
      gterm_b <= G_W'(g);
      sterm_b <= G_W'(da);
      xb <= xa; sb <= sa; fb <= fa; yb <= ya;
    end
  end

  // Consumption divider.
  localparam int CT_W = G_W + G_W + 31 + 31 + 32;
  logic cv;
  logic [CN_W-1:0] cq;
  logic [CT_W-1:0] ct;
  mbd_divider #(.NUM_W(CN_W), .DEN_W(17), .TAG_W(CT_W)) u_c_div (
    .clk, .rst, .advance,
    .in_valid(vb),
    .num(CN_W'(mux_b)),
    .den(yb),
    .tag_in({gterm_b, sterm_b, xb, sb, fb}),
    .out_valid(cv),
    .quo(cq),
    .tag_out(ct)
  );

  logic signed [G_W-1:0] gc, dc;
  logic [30:0] xc, sc;
  logic signed [31:0] fc;
  assign {gc, dc, xc, sc, fc} = ct;

  // Second operands: X and Sf - S, both fit 32 bits signed.
  logic signed [31:0] bx, bs;
  assign bx = signed'({1'b0, xc});
  assign bs = 32'(signed'({1'b0, sf})) - signed'({1'b0, sc});

  // Stage C1: split each 40-bit operand into a low unsigned and a high
  // signed piece, so every multiplier is at most 21 x 32 bits.
  logic vc1;
  logic signed [52:0] pxl, psl;
  logic signed [51:0] pxh, psh;
  logic [CN_W-1:0] cons_c1;
  logic [30:0] xc1, sc1;
  logic signed [31:0] fc1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc1 <= 1'b0;
    end else if (advance) begin
      vc1 <= cv;
    end
    if (advance) begin
      pxl <= $signed({1'b0, gc[G_LO-1:0]}) * bx;
      pxh <= $signed(gc[G_W-1:G_LO]) * bx;
      psl <= $signed({1'b0, dc[G_LO-1:0]}) * bs;
      psh <= $signed(dc[G_W-1:G_LO]) * bs;
      cons_c1 <= cq;
      xc1 <= xc; sc1 <= sc; fc1 <= fc;
    end
  end

  // Stage C2: add the pieces into the exact products.
  logic vc2;
  logic signed [71:0] pdx, pds;
  logic [CN_W-1:0] cons_c;
  logic [30:0] xc2, sc2;
  logic signed [31:0] fc2;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc2 <= 1'b0;
    end else if (advance) begin
      vc2 <= vc1;
    end
    if (advance) begin
      pdx <= (72'(pxh) <<< G_LO) + 72'(pxl);
      pds <= (72'(psh) <<< G_LO) + 72'(psl);
      cons_c <= cons_c1;
      xc2 <= xc1; sc2 <= sc1; fc2 <= fc1;
    end
  end

  // Stage D: shift toward minus infinity, saturate into the output register.
  function automatic logic signed [31:0] sat(input logic signed [71:0] v);
    if (v > MAXP) return 32'sh7fffffff;
    if (v < MINP) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= vc2;
    end
    if (advance) begin
      out_ch.data.biomass_rate <= sat(pdx >>> FRAC_BITS);
      out_ch.data.substrate_rate <= sat((pds >>> FRAC_BITS) -
                                        72'(signed'({1'b0, cons_c})));
      out_ch.data.volume_rate <= fc2;
      out_ch.data.biomass_clamped <= xc2;
      out_ch.data.substrate_clamped <= sc2;
    end
  end
endmodule

// File: hdl/mbd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Standalone; used by the top level for D, mu and consumption.
module mbd_divider #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] tag_out
);
  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] q_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] d_in;
    logic [TAG_W-1:0] t_in;
    logic v_in;
    logic [NUM_W-1:0] q_r;
    logic [DEN_W-1:0] rem_r;
    logic [DEN_W-1:0] d_r;
    logic [TAG_W-1:0] t_r;
    logic v_r;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] shifted;

    if (i == 0) begin : g_first
      assign q_in = num;
      assign rem_in = '0;
      assign d_in = den;
      assign t_in = tag_in;
      assign v_in = in_valid;
    end else begin : g_next
      assign q_in = g_stage[i-1].q_r;
      assign rem_in = g_stage[i-1].rem_r;
      assign d_in = g_stage[i-1].d_r;
      assign t_in = g_stage[i-1].t_r;
      assign v_in = g_stage[i-1].v_r;
    end

    assign shifted = {rem_in, q_in[NUM_W-1]};
    assign trial = shifted - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (advance) begin
        v_r <= v_in;
      end
      if (advance) begin
        if (!trial[DEN_W]) begin
          rem_r <= trial[DEN_W-1:0];
          q_r <= {q_in[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DEN_W-1:0];
          q_r <= {q_in[NUM_W-2:0], 1'b0};
        end
        d_r <= d_in;
        t_r <= t_in;
      end
    end
  end

  assign out_valid = g_stage[NUM_W-1].v_r;
  assign quo = g_stage[NUM_W-1].q_r;
  assign tag_out = g_stage[NUM_W-1].t_r;
endmodule

// File: dv/monod_bioreactor_derivatives_tb.sv
// Testbench for the Monod fed-batch bioreactor rate block: a predictor of
// dX, dS, dV and the clamped states checks every output transaction in order.
// Depends on mbd_pkg, mbd_stream_if and monod_bioreactor_derivatives.
`timescale 1ns / 1ps

module monod_bioreactor_derivatives_tb;
  localparam int FRAC = mbd_pkg::FRAC_BITS;
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam longint HUNDREDTH = (ONE_Q + 50) / 100;
  localparam longint WIDE_LIM = 64'sd1 <<< 62;
  localparam int LATENCY = 2 * FRAC + 100;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mbd_pkg::CFG_W-1:0] cfg_data;

  mbd_stream_if #(.payload_t(mbd_pkg::in_item_t)) in_ch ();
  mbd_stream_if #(.payload_t(mbd_pkg::out_item_t)) out_ch ();

  monod_bioreactor_derivatives uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor's copy of the parameter registers.
  longint mu_max, half_sat, yield_q, feed_sub, death_q;

  mbd_pkg::in_item_t pending_samples[$];
  mbd_pkg::out_item_t expected_rates[$];
  int errors;
  longint cycles;
  int send_idle_pct, recv_idle_pct;
  int hold_off;          // cycles left in a long receiver hold-off
  bit run_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(a*b / 2^FRAC), magnitude clamped at 2^62.
  function automatic longint fixed_mul(longint a, longint b);
    logic signed [127:0] prod;
    logic signed [127:0] q;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    q = prod >>> FRAC;
    if (q > 128'(WIDE_LIM)) q = 128'(WIDE_LIM);
    if (q < -128'(WIDE_LIM)) q = -128'(WIDE_LIM);
    return longint'(q);
  endfunction

  function automatic mbd_pkg::out_item_t predict_rates(mbd_pkg::in_item_t it);
    mbd_pkg::out_item_t r;
    longint x, s, v, f, dil, mu, den, yxs, consume, dx, ds;
    x = longint'(it.biomass);
    s = longint'(it.substrate);
    v = longint'(it.volume);
    f = it.feed_present ? longint'(it.feed_rate) : HUNDREDTH;
    if (x < 0) x = 0;
    if (s < 0) s = 0;
    if (v < HUNDREDTH) v = HUNDREDTH;
    dil = (f * ONE_Q) / v;
    den = half_sat + s;
    mu = (den == 0) ? 0 : (mu_max * s) / den;
    dx = clip32(fixed_mul(mu - death_q - dil, x));
    yxs = (yield_q == 0) ? 1 : yield_q;
    consume = (mu * x) / yxs;
    ds = clip32(fixed_mul(dil, feed_sub - s) - consume);
    r.biomass_rate = dx[31:0];
    r.substrate_rate = ds[31:0];
    r.volume_rate = f[31:0];
    r.biomass_clamped = x[30:0];
    r.substrate_clamped = s[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: offer the head of the pending queue, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rates.push_back(predict_rates(in_ch.data));
        void'(pending_samples.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (pending_samples.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                   pending_samples.size() > 0 &&
                   $urandom_range(99, 0) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_samples[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Monitor: compare each output transaction with the oldest expectation.
  always @(posedge clk) begin
    mbd_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_rates.size() == 0) begin
        $display("unexpected output transaction");
        errors++;
      end else begin
        want = expected_rates.pop_front();
        if (out_ch.data.biomass_rate !== want.biomass_rate)
          report_mismatch("biomass_rate", out_ch.data.biomass_rate, want.biomass_rate);
        if (out_ch.data.substrate_rate !== want.substrate_rate)
          report_mismatch("substrate_rate", out_ch.data.substrate_rate,
                          want.substrate_rate);
        if (out_ch.data.volume_rate !== want.volume_rate)
          report_mismatch("volume_rate", out_ch.data.volume_rate, want.volume_rate);
        if (out_ch.data.biomass_clamped !== want.biomass_clamped)
          report_mismatch("biomass_clamped", out_ch.data.biomass_clamped,
                          want.biomass_clamped);
        if (out_ch.data.substrate_clamped !== want.substrate_clamped)
          report_mismatch("substrate_clamped", out_ch.data.substrate_clamped,
                          want.substrate_clamped);
      end
    end
    if (cycles > CYCLE_LIMIT && !run_done) begin
      $display("monod_bioreactor_derivatives_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(mbd_pkg::cfg_reg_t idx, longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[mbd_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mbd_pkg::REG_MAX_GROWTH: mu_max = value & 'h3FFFF;
      mbd_pkg::REG_HALF_SAT:   half_sat = value & 'h7FFFF;
      mbd_pkg::REG_YIELD:      yield_q = value & 'h1FFFF;
      mbd_pkg::REG_FEED_SUB:   feed_sub = value & 'h7FFFFF;
      mbd_pkg::REG_DEATH:      death_q = value & 'h3FFF;
      default: ;
    endcase
  endtask

  task automatic load_params(longint m, longint k, longint y, longint sf, longint kd);
    write_reg(mbd_pkg::REG_MAX_GROWTH, m);
    write_reg(mbd_pkg::REG_HALF_SAT, k);
    write_reg(mbd_pkg::REG_YIELD, y);
    write_reg(mbd_pkg::REG_FEED_SUB, sf);
    write_reg(mbd_pkg::REG_DEATH, kd);
  endtask

  // Wait for the pipeline to drain before touching registers.
  task automatic drain;
    while (pending_samples.size() > 0 || in_ch.valid || expected_rates.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7, 0))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(3, 0);
      2: return 32'h7FFF_FFFF - $urandom_range(3, 0);
      3: return $urandom_range(700, 0);
      4: return -$urandom_range(700, 0);
      default: return $urandom_range(64 * 65536, 0);   // plausible process range
    endcase
  endfunction

  task automatic queue_sample(logic [31:0] x, logic [31:0] s, logic [31:0] v,
                              logic [31:0] f, logic fp);
    mbd_pkg::in_item_t it;
    it.biomass = x;
    it.substrate = s;
    it.volume = v;
    it.feed_rate = f;
    it.feed_present = fp;
    pending_samples.push_back(it);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_sample(rand_word(), rand_word(), rand_word(), rand_word(), $urandom_range(1, 0));
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    run_done = 0;
    hold_off = 0;
    send_idle_pct = 22;
    recv_idle_pct = 49;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    mu_max = 26214; half_sat = 6554; yield_q = 32768; feed_sub = 655360; death_q = 655;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, default feed, negative feed, tiny volume.
    queue_sample(32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 32'h0000_1000, 1'b1);
    queue_sample(32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 32'hFFFF_FFFF, 1'b0);
    queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    queue_sample(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
    queue_sample(32'h0003_0000, 32'h0001_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1);
    queue_sample(32'h0003_0000, 32'h0001_0000, 32'h0000_028F, 32'h8000_0000, 1'b1);
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    drain();

    // Zero growth denominator and zero yield: Ks = 0, yield = 0, kd = 0.
    load_params(131072, 0, 0, 6553600, 0);
    queue_sample(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
    queue_sample(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
    queue_sample(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
    queue_random(300);
    drain();

    // Lower extremes, roles of the idling swapped.
    load_params(655, 66, 655, 6554, 13107);
    send_idle_pct = 49;
    recv_idle_pct = 22;
    queue_random(300);
    drain();

    // Upper extremes; no idling, with a long hold-off so the input stalls.
    load_params(262143, 524287, 131071, 8388607, 16383);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 3 * LATENCY;
    queue_random(150);
    drain();

    // Back to mid-range values from reset.
    load_params(26214, 6554, 32768, 655360, 655);
    queue_random(190);
    drain();

    repeat (LATENCY) @(posedge clk);
    run_done = 1;
    if (errors == 0 && expected_rates.size() == 0)
      $display("monod_bioreactor_derivatives_tb: PASS");
    else
      $display("monod_bioreactor_derivatives_tb: FAIL");
    $finish;
  end
endmodule
